@@ rtl/cphit_pkg.sv @@
// Package for the circle versus polygon edge hit unit.
// Holds field widths and shared constants; depends on nothing.
`default_nettype none
package cphit_pkg;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned RadiusW   = 15;
  localparam int unsigned IndexW    = 10;
  localparam int unsigned MaxEdgesDefault = 1024;
  // Input tdata is 111 bits of fields, padded to 112.
  localparam int unsigned InDataW   = 112;
  localparam int unsigned OutDataW  = 16;
endpackage
`default_nettype wire

@@ rtl/cphit_mac.sv @@
// Shared signed multiply unit with a registered product.
// Depends on nothing; used by the top level.
`default_nettype none
module cphit_mac (
  input  wire logic        clk_i,
  input  wire logic signed [33:0] a_i,
  input  wire logic signed [33:0] b_i,
  output logic signed [67:0] p_o
);
  // One multiply per cycle, product registered.
  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end
endmodule
`default_nettype wire

@@ rtl/circle_polygon_edge_hit_unit.sv @@
// Top level of the circle versus polygon edge hit unit.
// Depends on cphit_pkg and cphit_mac.
`default_nettype none
// Each input item is one polygon edge with a circle. The block tests it
// exactly in integers with a single shared multiplier that forms the
// squares, the dot product and the final wide comparison products one
// after another; tready is low meanwhile. An edge with tlast high
// produces one result item (hit flag and the index of the first hitting
// edge) and clears the run state. The result waits in an output register
// while the next edge is already accepted; a later last edge holds in
// its final cycle until the earlier result has been taken.
module circle_polygon_edge_hit_unit #(
  parameter int unsigned MaxEdges = cphit_pkg::MaxEdgesDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid_i,
  output logic      s_axis_tready_o,
  // center_x, center_y, circle_radius, edge_start_x, edge_start_y,
  // edge_end_x, edge_end_y, zero pad (lowest first)
  input  wire logic [cphit_pkg::InDataW-1:0] s_axis_tdata_i,
  input  wire logic s_axis_tlast_i, // last_edge
  output logic      m_axis_tvalid_o,
  input  wire logic m_axis_tready_i,
  // hit, first_hit_index, zero pad (lowest first)
  output logic [cphit_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import cphit_pkg::*;

  localparam int unsigned CapI = (MaxEdges < 1024) ? MaxEdges - 1 : 1023;
  localparam logic [IndexW-1:0] Cap = IndexW'(CapI);

  typedef enum logic [3:0] {
    S_IDLE, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9, S_DEC,
    S_WAIT
  } state_e;

  state_e state_q;
  logic signed [16:0] fx_q, fy_q, gx_q, gy_q, lx_q, ly_q;
  logic [RadiusW-1:0] r_q;
  logic last_q;
  logic signed [67:0] acc_q;   // partial sums of a, q0, q1 and h
  logic signed [35:0] a_q, q0_q, q1_q, h_q;
  logic signed [67:0] lhs_q;
  logic hit_seen_q;
  logic [IndexW-1:0] first_q, cnt_q;
  logic out_v_q;
  logic out_hit_q;
  logic [IndexW-1:0] out_idx_q;

  logic signed [33:0] ma, mb;
  logic signed [67:0] mp;
  logic signed [15:0] cx, cy, sx, sy, ex, ey;
  logic edge_hit;
  logic emit;

  assign cx = s_axis_tdata_i[15:0];
  assign cy = s_axis_tdata_i[31:16];
  assign sx = s_axis_tdata_i[62:47];
  assign sy = s_axis_tdata_i[78:63];
  assign ex = s_axis_tdata_i[94:79];
  assign ey = s_axis_tdata_i[110:95];

  // Operand selection for the shared multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_q)
      S_M0: begin ma = 34'(lx_q); mb = 34'(lx_q); end
      S_M1: begin ma = 34'(ly_q); mb = 34'(ly_q); end
      S_M2: begin ma = 34'(fx_q); mb = 34'(fx_q); end
      S_M3: begin ma = 34'(fy_q); mb = 34'(fy_q); end
      S_M4: begin ma = 34'(gx_q); mb = 34'(gx_q); end
      S_M5: begin ma = 34'(gy_q); mb = 34'(gy_q); end
      S_M6: begin ma = 34'($signed({1'b0, r_q})); mb = ma; end
      S_M7: begin ma = 34'(lx_q); mb = 34'(fx_q); end
      S_M8: begin ma = 34'(ly_q); mb = 34'(fy_q); end
      S_M9: begin ma = 34'(a_q); mb = 34'(q0_q); end
      // h*h is reissued while the last cycle holds, so mp stays stable.
      S_DEC, S_WAIT: begin ma = 34'(h_q); mb = 34'(h_q); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  cphit_mac u_mac (.clk_i(clk_i), .a_i(ma), .b_i(mb), .p_o(mp));

  // Final decision from the collected terms; lhs_q holds a*q0 and mp holds
  // h*h in S_WAIT.
  always_comb begin
    if (a_q == 0) edge_hit = 1'b0;
    else if (q0_q == 0 || q1_q == 0) edge_hit = 1'b1;
    else if (q0_q[35] != q1_q[35]) edge_hit = 1'b1;
    else if (q0_q[35]) edge_hit = 1'b0;
    else if (!(h_q < 0 && -h_q < a_q)) edge_hit = 1'b0;
    else edge_hit = (mp >= lhs_q);
  end

  // A last edge loads the result register once it is free or being emptied.
  assign emit = (state_q == S_WAIT) && last_q && (!out_v_q || m_axis_tready_i);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {{(OutDataW-IndexW-1){1'b0}}, out_idx_q, out_hit_q};

  // Sequencer, run state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      hit_seen_q <= 1'b0;
      first_q <= '0;
      cnt_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (emit) out_v_q <= 1'b1;
      else if (out_v_q && m_axis_tready_i) out_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (s_axis_tvalid_i && s_axis_tready_o) begin
          fx_q <= 17'(sx) - 17'(cx);
          fy_q <= 17'(sy) - 17'(cy);
          gx_q <= 17'(ex) - 17'(cx);
          gy_q <= 17'(ey) - 17'(cy);
          lx_q <= 17'(ex) - 17'(sx);
          ly_q <= 17'(ey) - 17'(sy);
          r_q  <= s_axis_tdata_i[46:32];
          last_q <= s_axis_tlast_i;
          state_q <= S_M0;
        end
        S_M0: state_q <= S_M1;
        S_M1: begin acc_q <= mp; state_q <= S_M2; end
        S_M2: begin a_q <= 36'(acc_q + mp); state_q <= S_M3; end
        S_M3: begin acc_q <= mp; state_q <= S_M4; end
        S_M4: begin acc_q <= acc_q + mp; state_q <= S_M5; end
        S_M5: begin q0_q <= 36'(acc_q); acc_q <= mp; state_q <= S_M6; end
        S_M6: begin acc_q <= acc_q + mp; state_q <= S_M7; end
        S_M7: begin
          q0_q <= 36'(68'(q0_q) - mp);
          q1_q <= 36'(acc_q - mp);
          state_q <= S_M8;
        end
        S_M8: begin acc_q <= mp; state_q <= S_M9; end
        S_M9: begin h_q <= 36'(acc_q + mp); state_q <= S_DEC; end
        S_DEC: begin state_q <= S_WAIT; end
        S_WAIT: if (!last_q || emit) begin
          state_q <= S_IDLE;
          if (last_q) begin
            out_hit_q <= hit_seen_q || edge_hit;
            out_idx_q <= hit_seen_q ? first_q : (edge_hit ? cnt_q : '0);
            hit_seen_q <= 1'b0;
            first_q <= '0;
            cnt_q <= '0;
          end else begin
            if (edge_hit && !hit_seen_q) begin
              hit_seen_q <= 1'b1;
              first_q <= cnt_q;
            end
            if (cnt_q < Cap) cnt_q <= cnt_q + 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      // a*q0 product, issued in S_M9, is on mp during S_DEC.
      if (state_q == S_DEC) lhs_q <= mp;
    end
  end
endmodule
`default_nettype wire

@@ bench/tb_circle_polygon_edge_hit_unit.sv @@
// Testbench for the circle versus polygon edge hit unit.
// Drives edge items with random gaps, predicts hit results, checks them in order.
// Depends on cphit_pkg and circle_polygon_edge_hit_unit.
`default_nettype none
module tb_circle_polygon_edge_hit_unit;
  import cphit_pkg::*;

  typedef struct packed {
    logic signed [15:0] ey;
    logic signed [15:0] ex;
    logic signed [15:0] sy;
    logic signed [15:0] sx;
    logic [14:0]        r;
    logic signed [15:0] cy;
    logic signed [15:0] cx;
  } edge_t;

  typedef struct {
    edge_t e;
    logic  last;
  } edge_item_t;

  typedef struct {
    logic       hit;
    logic [9:0] idx;
  } hit_result_t;

  localparam int unsigned EdgeCap = 1023;
  localparam longint unsigned CycleLimit = 2_000_000;

  logic clk_i;
  logic rst_ni;
  logic s_tvalid;
  logic s_tready;
  logic [InDataW-1:0] s_tdata;
  logic s_tlast;
  logic m_tvalid;
  logic m_tready;
  logic [OutDataW-1:0] m_tdata;

  circle_polygon_edge_hit_unit dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata),
    .s_axis_tlast_i(s_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata)
  );

  edge_item_t  pending_edges[$];
  hit_result_t expected_hits[$];
  logic        run_hit;
  logic [9:0]  run_first;
  logic [9:0]  run_count;
  int          mismatches;
  int          hold_cycles;
  int          long_hold_left;
  logic        stim_done;
  logic        pause_req;
  int          gap_left;
  longint unsigned cycle_count;

  // Exact hit decision for one edge against the circle.
  function automatic logic edge_hits_circle(edge_t e);
    longint fx, fy, gx, gy, lx, ly, a, rr, q0, q1, h;
    logic [127:0] lhs, rhs;
    fx = e.sx - e.cx; fy = e.sy - e.cy;
    gx = e.ex - e.cx; gy = e.ey - e.cy;
    lx = e.ex - e.sx; ly = e.ey - e.sy;
    a  = lx * lx + ly * ly;
    rr = longint'(e.r) * longint'(e.r);
    if (a == 0) return 1'b0;
    q0 = fx * fx + fy * fy - rr;
    q1 = gx * gx + gy * gy - rr;
    if (q0 == 0 || q1 == 0) return 1'b1;
    if ((q0 < 0) != (q1 < 0)) return 1'b1;
    if (q0 < 0) return 1'b0;
    h = lx * fx + ly * fy;
    if (!(h < 0 && -h < a)) return 1'b0;
    lhs = 128'(-h) * 128'(-h);
    rhs = 128'(a) * 128'(q0);
    return lhs >= rhs;
  endfunction

  // Update the run state for an accepted edge and queue a result on the last one.
  task automatic predict_edge(edge_item_t it);
    if (edge_hits_circle(it.e) && !run_hit) begin
      run_hit   = 1'b1;
      run_first = run_count;
    end
    if (run_count < EdgeCap) run_count = run_count + 1'b1;
    if (it.last) begin
      expected_hits.push_back('{hit: run_hit, idx: run_hit ? run_first : 10'd0});
      run_hit = 1'b0;
      run_first = '0;
      run_count = '0;
    end
  endtask

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
      2: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
      default: return $signed(16'($urandom_range(0, 255))) - 16'sd128;
    endcase
  endfunction

  // Edge mostly near a random circle so that hits, misses and inside cases all occur.
  function automatic edge_t rand_edge();
    edge_t e;
    int span;
    span = $urandom_range(0, 3) == 0 ? 32767 : 600;
    e.cx = rand_coord();
    e.cy = rand_coord();
    e.r  = ($urandom_range(0, 7) == 0) ? 15'($urandom) : 15'($urandom_range(0, 400));
    e.sx = 16'(int'(e.cx) + $urandom_range(0, 2 * span) - span);
    e.sy = 16'(int'(e.cy) + $urandom_range(0, 2 * span) - span);
    e.ex = ($urandom_range(0, 15) == 0) ? e.sx :
           16'(int'(e.cx) + $urandom_range(0, 2 * span) - span);
    e.ey = ($urandom_range(0, 15) == 0) ? e.sy :
           16'(int'(e.cy) + $urandom_range(0, 2 * span) - span);
    if ($urandom_range(0, 9) == 0)
      e = edge_t'(111'({$urandom, $urandom, $urandom, $urandom}));
    return e;
  endfunction

  function automatic edge_t mk(int cx, int cy, int r, int sx, int sy, int ex, int ey);
    edge_t e;
    e.cx = 16'(cx); e.cy = 16'(cy); e.r = 15'(r);
    e.sx = 16'(sx); e.sy = 16'(sy); e.ex = 16'(ex); e.ey = 16'(ey);
    return e;
  endfunction

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stimulus: directed cases, then random polygons.
  initial begin
    int n, len;
    rst_ni = 1'b0;
    stim_done = 1'b0;
    pause_req = 1'b0;
    // Zero-length edge.
    pending_edges.push_back('{mk(0, 0, 100, 50, 50, 50, 50), 1'b1});
    // Edge wholly inside.
    pending_edges.push_back('{mk(0, 0, 100, 10, 0, -10, 0), 1'b1});
    // Tangent line, endpoint on the boundary, crossing, miss.
    pending_edges.push_back('{mk(0, 0, 100, -200, 100, 200, 100), 1'b0});
    pending_edges.push_back('{mk(0, 0, 100, 100, 0, 300, 0), 1'b0});
    pending_edges.push_back('{mk(0, 0, 100, 0, 0, 300, 0), 1'b0});
    pending_edges.push_back('{mk(0, 0, 100, 500, 500, 600, 700), 1'b1});
    // Extremes of every field.
    pending_edges.push_back('{mk(-32768, 32767, 32767, 32767, -32768, -32768, 32767), 1'b0});
    pending_edges.push_back('{mk(32767, -32768, 0, -32768, -32768, 32767, 32767), 1'b0});
    pending_edges.push_back('{mk(-32768, -32768, 32767, 32767, 32767, 32767, 32767), 1'b1});
    pending_edges.push_back('{mk(0, 0, 0, -5, 0, 5, 0), 1'b1});
    pending_edges.push_back('{mk(0, 0, 0, 5, 0, 9, 0), 1'b1});
    // Overlong run: counter saturates, first hit after the cap.
    for (int i = 0; i < 1100; i++)
      pending_edges.push_back('{i < 1060 ? mk(0, 0, 10, 500, 500, 600, 600)
                                         : mk(0, 0, 100, -200, 0, 200, 0), i == 1099});
    n = 0;
    while (n < 690) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        pending_edges.push_back('{rand_edge(), k == len - 1});
        n++;
      end
      // A few single-edge queries partway through.
      if (n >= 340 && n < 349) pending_edges.push_back('{rand_edge(), 1'b1});
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Sender pause until every expected result has come.
    wait (pending_edges.size() < 1200);
    pause_req <= 1'b1;
    wait (expected_hits.size() == 0 && !s_tvalid);
    repeat (30) @(posedge clk_i);
    pause_req <= 1'b0;
    wait (pending_edges.size() == 0 && !s_tvalid);
    stim_done <= 1'b1;
  end

  // Driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tlast  <= 1'b0;
      gap_left <= 0;
      run_hit = 1'b0;
      run_first = '0;
      run_count = '0;
    end else begin
      edge_item_t it;
      if (s_tvalid && s_tready) predict_edge('{edge_t'(s_tdata[110:0]), s_tlast});
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          s_tvalid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_edges.size() > 0 && !pause_req) begin
          it = pending_edges.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {1'b0, it.e};
          s_tlast  <= it.last;
          gap_left <= ($urandom_range(0, 2) != 0) ? 0 :
                      ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 3);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold right after reset while the sender keeps offering.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_hold_left <= 400;
    end else if (long_hold_left > 0) begin
      long_hold_left <= long_hold_left - 1;
    end
  end

  // Receiver stall generator and checker.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
      hold_cycles <= 0;
      mismatches = 0;
    end else begin
      hit_result_t exp;
      if (m_tvalid && m_tready) begin
        if (expected_hits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", m_tdata);
        end else begin
          exp = expected_hits.pop_front();
          if (m_tdata[0] !== exp.hit || m_tdata[10:1] !== exp.idx
              || m_tdata[15:11] !== 5'd0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected hit %b index %0d, got hit %b index %0d",
                       exp.hit, exp.idx, m_tdata[0], m_tdata[10:1]);
          end
        end
      end
      if (long_hold_left > 0) begin
        m_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        if ($urandom_range(0, 30) == 0) hold_cycles <= $urandom_range(10, 60);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Run end and timeout.
  initial begin
    cycle_count = 0;
    fork
      begin
        wait (stim_done && expected_hits.size() == 0);
        repeat (100) @(posedge clk_i);
        if (mismatches == 0 && expected_hits.size() == 0) begin
          $display("[ OK ] regression clean");
        end else begin
          $display("[FAIL] regression broken");
        end
      end
      begin
        while (cycle_count < CycleLimit) begin
          @(posedge clk_i);
          cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("[FAIL] regression broken");
      end
    join_any
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
rtl/cphit_pkg.sv
rtl/cphit_mac.sv
rtl/circle_polygon_edge_hit_unit.sv
bench/tb_circle_polygon_edge_hit_unit.sv
